// ===== rtl/rass_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the random axis-angle sampler.
// No dependencies.
package rass_pkg;

  localparam int unsigned ONE_Q16    = 65536;
  localparam int unsigned PI_Q16     = 205887;
  localparam int unsigned DEG180_Q16 = 11796480;
  localparam int unsigned CORDIC_K   = 652032874;
  localparam int unsigned ITERS      = 24;
  localparam int unsigned ROOT_ITERS = 17;
  localparam int unsigned IDX_W      = $clog2(ITERS);

  localparam logic [1:0] CFG_MAX_ANGLE  = 2'd0;
  localparam logic [1:0] CFG_ANGLE_LAW  = 2'd1;
  localparam logic [1:0] CFG_ANGLE_UNIT = 2'd2;

  typedef struct packed {
    logic               err;
    logic               zero;
    logic signed [17:0] zq;
    logic [1:0]         quad;
    logic [16:0]        n3;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [32:0] ca;
    logic [33:0]        sq_rad;
    logic [21:0]        sq_rem;
    logic [16:0]        sq_root;
    logic [50:0]        cb_rad;
    logic [39:0]        cb_rem;
    logic [16:0]        cb_y;
    logic [33:0]        cb_y2;
  } stage_t;

  function automatic logic signed [32:0] turn_atan(input logic [IDX_W-1:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

// ===== rtl/rass_iter_stage.sv =====
// One registered iteration: a CORDIC step, plus square- and cube-root digits while k < 17.
// Depends on rass_pkg.
module rass_iter_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [rass_pkg::IDX_W-1:0]    k,
  input  logic                          in_valid,
  input  rass_pkg::stage_t              in_data,
  output logic                          out_valid,
  output rass_pkg::stage_t              out_data
);
  import rass_pkg::*;

  stage_t             d_next;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic [21:0]        sq_sh;
  logic [21:0]        sq_test;
  logic [39:0]        cb_sh;
  logic [39:0]        cb_test;
  logic [33:0]        y2x4;
  logic               roots_on;

  always_comb begin
    d_next   = in_data;
    roots_on = ({1'b0, k} < (IDX_W + 1)'(ROOT_ITERS));
    xs = in_data.cx >>> k;
    ys = in_data.cy >>> k;
    if (!in_data.ca[32]) begin
      d_next.cx = in_data.cx - ys;
      d_next.cy = in_data.cy + xs;
      d_next.ca = in_data.ca - turn_atan(k);
    end else begin
      d_next.cx = in_data.cx + ys;
      d_next.cy = in_data.cy - xs;
      d_next.ca = in_data.ca + turn_atan(k);
    end

    sq_sh   = {in_data.sq_rem[19:0], in_data.sq_rad[33:32]};
    sq_test = {3'b0, in_data.sq_root, 2'b01};
    cb_sh   = {in_data.cb_rem[36:0], in_data.cb_rad[50:48]};
    cb_test = ({6'b0, in_data.cb_y2} << 3) + ({6'b0, in_data.cb_y2} << 2)
            + ({23'b0, in_data.cb_y} << 2) + ({23'b0, in_data.cb_y} << 1) + 40'd1;
    y2x4    = {in_data.cb_y2[31:0], 2'b00};
    if (roots_on) begin
      d_next.sq_rad = {in_data.sq_rad[31:0], 2'b00};
      if (sq_sh >= sq_test) begin
        d_next.sq_rem  = sq_sh - sq_test;
        d_next.sq_root = {in_data.sq_root[15:0], 1'b1};
      end else begin
        d_next.sq_rem  = sq_sh;
        d_next.sq_root = {in_data.sq_root[15:0], 1'b0};
      end
      d_next.cb_rad = {in_data.cb_rad[47:0], 3'b000};
      if (cb_sh >= cb_test) begin
        d_next.cb_rem = cb_sh - cb_test;
        d_next.cb_y   = {in_data.cb_y[15:0], 1'b1};
        d_next.cb_y2  = y2x4 + {15'b0, in_data.cb_y, 2'b00} + 34'd1;
      end else begin
        d_next.cb_rem = cb_sh;
        d_next.cb_y   = {in_data.cb_y[15:0], 1'b0};
        d_next.cb_y2  = y2x4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= d_next;
    end
  end

endmodule

// ===== rtl/random_axis_angle_sampler.sv =====
// Random axis-angle sampler: uniform unit axis on the sphere plus a bounded rotation angle.
// Depends on rass_pkg and rass_iter_stage.
// One transaction per cycle in and out while the output is not stalled. Each transaction passes
// through the input register, setup stage, 24 CORDIC iterations (one stage each, with the 17-digit
// square and cube roots running alongside), product stage and output register. A stall at the
// output holds the whole pipeline.
module random_axis_angle_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // polar_draw[16:0], azimuth_draw[33:17], angle_draw[50:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // axis_x[15:0], axis_y[31:16], axis_z[47:32], angle[71:48]
  output logic [0:0]  m_axis_tuser,   // range_error[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import rass_pkg::*;

  typedef struct packed {
    logic               err;
    logic               zero;
    logic signed [17:0] zq;
    logic signed [49:0] px;
    logic signed [49:0] py;
    logic [40:0]        pa;
  } mult_t;

  logic [23:0] max_angle;
  logic        angle_law;
  logic        angle_unit;
  logic        en;

  logic        s0_valid;
  logic [16:0] s0_polar, s0_azim, s0_ang;
  logic        p_valid;
  stage_t      p_data;
  stage_t      p_next;
  logic                 iv [ITERS+1];
  stage_t               idat [ITERS+1];
  logic                 mv;
  mult_t                md;
  mult_t                m_next;

  logic signed [18:0] zq_w;
  logic signed [35:0] zsq;
  logic [35:0]        rad36;
  logic signed [31:0] cvv, svv;
  logic [23:0]        m_clamp;
  logic [16:0]        c_sel;
  logic signed [50:0] rx, ry;
  logic signed [18:0] qx, qy;
  logic signed [18:0] zr;
  logic [41:0]        ar;
  logic [15:0]        ax, ay, azv;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_angle  <= 24'(DEG180_Q16);
      angle_law  <= 1'b0;
      angle_unit <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_ANGLE:  max_angle  <= cfg_data;
        CFG_ANGLE_LAW:  angle_law  <= cfg_data[0];
        CFG_ANGLE_UNIT: angle_unit <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      p_valid  <= 1'b0;
    end else if (en) begin
      s0_valid <= s_axis_tvalid;
      p_valid  <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_polar <= s_axis_tdata[16:0];
      s0_azim  <= s_axis_tdata[33:17];
      s0_ang   <= s_axis_tdata[50:34];
      p_data   <= p_next;
    end
  end

  always_comb begin
    zq_w  = $signed({1'b0, s0_polar, 1'b0}) - 19'sd65536;
    zsq   = $signed(zq_w[17:0]) * $signed(zq_w[17:0]);
    rad36 = 36'h1_0000_0000 - $unsigned(zsq);
    p_next.err  = (s0_polar > 17'(ONE_Q16)) || (s0_azim > 17'(ONE_Q16))
               || (s0_ang > 17'(ONE_Q16));
    p_next.zero    = (s0_polar == 17'd0);
    p_next.zq      = zq_w[17:0];
    p_next.quad    = s0_azim[15:14];
    p_next.n3      = s0_ang;
    p_next.cx      = 34'(CORDIC_K);
    p_next.cy      = '0;
    p_next.ca      = $signed({3'b000, s0_azim[13:0], 16'h0000});
    p_next.sq_rad  = rad36[33:0];
    p_next.sq_rem  = '0;
    p_next.sq_root = '0;
    p_next.cb_rad  = {2'b00, s0_ang, 32'h0};
    p_next.cb_rem  = '0;
    p_next.cb_y    = '0;
    p_next.cb_y2   = '0;
  end

  assign iv[0]   = p_valid;
  assign idat[0] = p_data;

  for (genvar g = 0; g < ITERS; g++) begin : g_iter
    rass_iter_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .k         (IDX_W'(g)),
      .in_valid  (iv[g]),
      .in_data   (idat[g]),
      .out_valid (iv[g+1]),
      .out_data  (idat[g+1])
    );
  end

  always_comb begin
    unique case (idat[ITERS].quad)
      2'd0: begin cvv = idat[ITERS].cx[31:0];    svv = idat[ITERS].cy[31:0];    end
      2'd1: begin cvv = -idat[ITERS].cy[31:0];   svv = idat[ITERS].cx[31:0];    end
      2'd2: begin cvv = -idat[ITERS].cx[31:0];   svv = -idat[ITERS].cy[31:0];   end
      default: begin cvv = idat[ITERS].cy[31:0]; svv = -idat[ITERS].cx[31:0];  end
    endcase
    if (angle_unit) begin
      m_clamp = (max_angle > 24'(DEG180_Q16)) ? 24'(DEG180_Q16) : max_angle;
    end else begin
      m_clamp = (max_angle > 24'(PI_Q16)) ? 24'(PI_Q16) : max_angle;
    end
    c_sel       = angle_law ? idat[ITERS].n3 : idat[ITERS].cb_y;
    m_next.err  = idat[ITERS].err;
    m_next.zero = idat[ITERS].zero;
    m_next.zq   = idat[ITERS].zq;
    m_next.px   = $signed({1'b0, idat[ITERS].sq_root}) * cvv;
    m_next.py   = $signed({1'b0, idat[ITERS].sq_root}) * svv;
    m_next.pa   = m_clamp * c_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      mv            <= iv[ITERS];
      m_axis_tvalid <= mv;
    end
  end

  always_comb begin
    rx  = 51'(md.px) + 51'sd2147483648;
    ry  = 51'(md.py) + 51'sd2147483648;
    qx  = rx[50:32];
    qy  = ry[50:32];
    zr  = 19'(md.zq) + 19'sd2;
    ar  = 42'(md.pa) + 42'd32768;
    ax  = (qx > 19'sd16384) ? 16'sd16384 : (qx < -19'sd16384) ? -16'sd16384 : qx[15:0];
    ay  = (qy > 19'sd16384) ? 16'sd16384 : (qy < -19'sd16384) ? -16'sd16384 : qy[15:0];
    azv = zr[17:2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= md.err;
      if (md.err) begin
        m_axis_tdata <= '0;
      end else if (md.zero) begin
        m_axis_tdata <= {ar[39:16], 16'sd16384, 16'd0, 16'd0};
      end else begin
        m_axis_tdata <= {ar[39:16], azv, ay, ax};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md <= m_next;
    end
  end

endmodule

// ===== rtl/rass_checker.sv =====
// Port-level checks for the random axis-angle sampler, bound to the top level.
// Depends on random_axis_angle_sampler.
module rass_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 72'd0)
    else $error("range error transaction carries nonzero data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind random_axis_angle_sampler rass_checker u_rass_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/axis_angle_checker.sv =====
// Checker for the random axis-angle sampler: watches the config, input and output channels.
// Computes each expected axis and angle at input acceptance and compares it in order.
// Depends on rass_pkg.
module axis_angle_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rass_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [23:0]        angle;
    logic               range_error;
  } sample_t;

  localparam longint ATAN_TURN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic [23:0] max_angle_q;
  logic        angle_law_q;
  logic        angle_unit_q;
  sample_t     expected_samples[$];

  function automatic longint clamp14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint root_search(longint v, bit cube);
    longint lo, hi, mid, p;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      p = cube ? mid * mid * mid : mid * mid;
      if (p <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic sample_t predict_sample(logic [16:0] n1, logic [16:0] n2, logic [16:0] n3);
    sample_t r;
    longint zq, s, x, y, nx, ny, ang, cv, sv, m, c;
    r = '0;
    if (n1 > ONE_Q16 || n2 > ONE_Q16 || n3 > ONE_Q16) begin
      r.range_error = 1'b1;
      return r;
    end
    if (n1 == 0) begin
      r.az = 16'sd16384;
    end else begin
      zq = 2 * longint'(n1) - 65536;
      s = root_search((64'sd1 << 32) - zq * zq, 1'b0);
      x = CORDIC_K;
      y = 0;
      ang = longint'(n2[13:0]) << 16;
      for (int i = 0; i < 24; i++) begin
        if (ang >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          ang -= ATAN_TURN[i];
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          ang += ATAN_TURN[i];
        end
        x = nx;
        y = ny;
      end
      case (n2[15:14])
        2'd0: begin cv = x;  sv = y;  end
        2'd1: begin cv = -y; sv = x;  end
        2'd2: begin cv = -x; sv = -y; end
        default: begin cv = y; sv = -x; end
      endcase
      r.az = 16'(clamp14((zq + 2) >>> 2));
      r.ax = 16'(clamp14((s * cv + (64'sd1 << 31)) >>> 32));
      r.ay = 16'(clamp14((s * sv + (64'sd1 << 31)) >>> 32));
    end
    m = max_angle_q;
    if (angle_unit_q) begin
      if (m > DEG180_Q16) m = DEG180_Q16;
    end else begin
      if (m > PI_Q16) m = PI_Q16;
    end
    c = angle_law_q ? longint'(n3) : root_search(longint'(n3) << 32, 1'b1);
    r.angle = 24'((m * c + 32768) >> 16);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  assign outstanding = expected_samples.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    sample_t got, want;
    if (rst) begin
      max_angle_q  <= 24'(DEG180_Q16);
      angle_law_q  <= 1'b0;
      angle_unit_q <= 1'b1;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_ANGLE:  max_angle_q  <= cfg_data;
          CFG_ANGLE_LAW:  angle_law_q  <= cfg_data[0];
          CFG_ANGLE_UNIT: angle_unit_q <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_samples.push_back(predict_sample(s_axis_tdata[16:0], s_axis_tdata[33:17],
                                                  s_axis_tdata[50:34]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.ax = m_axis_tdata[15:0];
        got.ay = m_axis_tdata[31:16];
        got.az = m_axis_tdata[47:32];
        got.angle = m_axis_tdata[71:48];
        got.range_error = m_axis_tuser[0];
        if (expected_samples.size() == 0) begin
          report("unexpected transaction, angle", got.angle, 0);
        end else begin
          want = expected_samples.pop_front();
          if (got.ax !== want.ax) report("axis_x", got.ax, want.ax);
          if (got.ay !== want.ay) report("axis_y", got.ay, want.ay);
          if (got.az !== want.az) report("axis_z", got.az, want.az);
          if (got.angle !== want.angle) report("angle", got.angle, want.angle);
          if (got.range_error !== want.range_error)
            report("range_error", got.range_error, want.range_error);
        end
      end
    end
  end
endmodule

// ===== verif/random_axis_angle_sampler_tb.sv =====
// Top of the random axis-angle sampler testbench: clock, reset, stimulus and verdict.
// Depends on rass_pkg, random_axis_angle_sampler and axis_angle_checker.
module random_axis_angle_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rass_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 800000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  int          mismatches;
  int          outstanding;
  int          cycles;
  int          sent;
  int          settings;
  bit          calm;

  random_axis_angle_sampler dut (.*);

  axis_angle_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  function automatic logic [16:0] pick_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 17'(65536 + $urandom_range(1, 65535));
    if (r < 8) return 17'd0;
    if (r < 12) return 17'd65536;
    return 17'($urandom_range(0, 65536));
  endfunction

  task automatic send_draws(logic [16:0] polar, logic [16:0] azim, logic [16:0] adraw);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, adraw, azim, polar};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [23:0] max_a, logic law, logic unit);
    write_reg(CFG_MAX_ANGLE, max_a);
    write_reg(CFG_ANGLE_LAW, {23'($urandom), law});
    write_reg(CFG_ANGLE_UNIT, {23'($urandom), unit});
    settings++;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_ANGLE;
    cfg_data = '0;
    calm = 1'b0;
    sent = 0;
    settings = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_draws(17'd0, 17'd0, 17'd0);
    send_draws(17'd65536, 17'd65536, 17'd65536);
    send_draws(17'd1, 17'd0, 17'd1);
    send_draws(17'd65535, 17'd65535, 17'd65535);
    send_draws(17'd32768, 17'd0, 17'd32768);
    send_draws(17'd32768, 17'd16384, 17'd8192);
    send_draws(17'd32768, 17'd32768, 17'd4096);
    send_draws(17'd32768, 17'd49152, 17'd1000);
    send_draws(17'd0, 17'd12345, 17'd54321);
    send_draws(17'd65537, 17'd0, 17'd0);
    send_draws(17'd0, 17'd65537, 17'd0);
    send_draws(17'd0, 17'd0, 17'd65537);
    send_draws(17'd131071, 17'd131071, 17'd131071);
    send_draws(17'd21845, 17'd10923, 17'd43690);
    send_draws(17'd43690, 17'd54613, 17'd21845);

    write_reg(CFG_UNUSED, 24'hFFFFFF);
    send_draws(17'd40000, 17'd20000, 17'd65536);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setting(24'd0, 1'b0, 1'b0);
        1: apply_setting(24'hFFFFFF, 1'b1, 1'b1);
        2: apply_setting(24'hFFFFFF, 1'b0, 1'b0);
        3: apply_setting(24'(PI_Q16), 1'b1, 1'b0);
        4: apply_setting(24'($urandom), 1'($urandom), 1'($urandom));
        default: begin
          apply_setting(24'(DEG180_Q16), 1'b0, 1'b1);
          calm = 1'b1;
        end
      endcase
      for (int k = 0; k < 265; k++) send_draws(pick_draw(), pick_draw(), pick_draw());
    end
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d draw transactions under %0d angle settings, with stalls on both sides",
             sent, settings);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end
endmodule
